FILE: hw/rtl/ccmm_pkg.sv
// Package for the channel column metal maximizer.
// Holds the beat payload types, the run state type, register indexes and
// reset values. No dependencies.
package ccmm_pkg;

	// Largest track count that the channel width register accepts.
	localparam int MAX_TRACKS = 254;

	// Saturation limit as an 8-bit value, since the register is 8 bits wide.
	localparam logic [7:0] MAX_TRACKS_W8 = (MAX_TRACKS > 255) ? 8'd255 : 8'(MAX_TRACKS);

	// Reset values of the configuration registers.
	localparam logic [7:0] VIA_LIMIT_RST     = 8'd2;
	localparam logic [7:0] CHANNEL_WIDTH_RST = (MAX_TRACKS_W8 < 8'd254) ? MAX_TRACKS_W8 : 8'd254;

	// Configuration register indexes.
	typedef enum logic [7:0] {
		REG_VIA_LIMIT     = 8'd0,
		REG_CHANNEL_WIDTH = 8'd1
	} cfg_reg_t;

	// One grid point of the column.
	typedef struct packed {
		logic [7:0] row;
		logic       goes_up;
		logic       goes_right;
		logic       has_contact;
		logic       metal_blocked;
		logic       left_goes_right;
		logic       metal_ok_beyond;
	} point_t;

	// One closed span.
	typedef struct packed {
		logic       convert;
		logic [7:0] span_bottom;
		logic [7:0] span_top;
		logic       contact_at_bottom;
		logic       contact_at_top;
	} span_t;

	// Open-run tracking state carried from point to point.
	typedef struct packed {
		logic       run_open;
		logic [7:0] run_start;
		logic       low_contact_needed;
		logic       low_contact_present;
		logic       prior_row_contact;
	} run_state_t;

	// Configuration register values.
	typedef struct packed {
		logic [7:0] via_limit;
		logic [7:0] channel_width;
	} cfg_t;

endpackage

FILE: hw/rtl/ccmm_point.sv
// Per-point decision logic of the channel column metal maximizer.
// Purely combinational: next run state and the optional closed span.
// Depends on ccmm_pkg.
module ccmm_point (
	input  ccmm_pkg::cfg_t       cfg,
	input  ccmm_pkg::run_state_t state,
	input  ccmm_pkg::point_t     point,
	output ccmm_pkg::run_state_t state_next,
	output logic                 span_valid,
	output ccmm_pkg::span_t      span
);
	import ccmm_pkg::*;

	logic [8:0] top_row;
	logic       through;
	logic       crossing;
	logic       ignored;
	logic       closes;
	logic [7:0] top;
	logic       need_hi;
	logic       has_hi;
	logic [7:0] span_len;
	logic       too_many_vias;
	logic       convert;

	// The top boundary row sits one above the last track.
	assign top_row  = {1'b0, cfg.channel_width} + 9'd1;
	assign through  = point.goes_right && point.left_goes_right;
	assign crossing = through && !point.has_contact;
	assign ignored  = {1'b0, point.row} > top_row;

	// Decide whether this point closes the open run, and where its top is.
	always_comb begin
		closes  = 1'b0;
		top     = point.row - 8'd1;
		need_hi = 1'b1;
		has_hi  = state.prior_row_contact;
		if (!ignored && point.row != 8'd0 && state.run_open) begin
			priority if (point.metal_blocked || crossing) begin
				closes = 1'b1;
			end else if ({1'b0, point.row} == top_row) begin
				closes = 1'b1;
				if (point.metal_ok_beyond) begin
					top     = point.row;
					need_hi = 1'b0;
					has_hi  = 1'b0;
				end
			end else if (!point.goes_up) begin
				closes  = 1'b1;
				top     = point.row;
				need_hi = 1'b0;
				has_hi  = 1'b1;
			end else begin
				// The run carries on upward.
				closes = 1'b0;
			end
		end
	end

	// Two new vias arise only when both ends need one and neither has one.
	assign too_many_vias = state.low_contact_needed && need_hi && !has_hi &&
		!state.low_contact_present;
	assign span_len = top - state.run_start;
	assign convert  = (state.run_start < top) &&
		(!too_many_vias || span_len >= cfg.via_limit);

	assign span_valid             = closes;
	assign span.convert           = convert;
	assign span.span_bottom       = state.run_start;
	assign span.span_top          = top;
	assign span.contact_at_bottom = convert && state.low_contact_needed;
	assign span.contact_at_top    = convert && need_hi;

	// Next run state.
	always_comb begin
		state_next = state;
		if (!ignored) begin
			state_next.prior_row_contact = point.has_contact;
			if (point.row == 8'd0) begin
				state_next.run_open = point.goes_up && point.metal_ok_beyond &&
					!point.metal_blocked;
				if (state_next.run_open) begin
					state_next.run_start           = 8'd0;
					state_next.low_contact_needed  = 1'b0;
					state_next.low_contact_present = 1'b0;
				end
			end else if (!state.run_open) begin
				if (!point.metal_blocked && point.goes_up && !crossing) begin
					state_next.run_open            = 1'b1;
					state_next.run_start           = point.row;
					state_next.low_contact_needed  = !through;
					state_next.low_contact_present = point.has_contact;
				end
			end else if (closes) begin
				state_next.run_open = 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/channel_column_metal_maximizer_core.sv
// Top level of the channel column metal maximizer.
// Input register, per-point decision logic and result register.
// Depends on ccmm_pkg and ccmm_point.
//
// Usage: grid points of a column enter bottom to top on the in channel,
// one beat per point (in_valid / in_stall). A point with row 0 starts a
// new column. Each point that closes an open vertical run yields one beat
// on the out channel (out_valid / out_stall) with the span and whether it
// becomes metal; other points yield nothing.
// A point passes the input register, then the result register. Unless the
// receiver stalls, one point is accepted every cycle: the input register
// feeds the decision logic, whose run state updates as the point moves
// into the result register, so the next point follows in the next cycle.
// When the receiver stalls, the result register holds its beat and the
// input register holds one more point; in_stall rises only when both are
// full. Configuration writes (cfg_valid / cfg_ready, always ready) set
// via_limit (index 0) and channel_width (index 1); they are meant for
// idle periods. Reset clears the run state, empties both registers and
// loads via_limit = 2 and channel_width = 254.
module channel_column_metal_maximizer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ccmm_pkg::point_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ccmm_pkg::span_t  out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [7:0]       cfg_data
);
	import ccmm_pkg::*;

	cfg_t       cfg_q;
	run_state_t state_q;
	run_state_t state_next;
	point_t     point_s1;
	logic       valid_s1;
	span_t      span_c;
	logic       span_valid_c;
	span_t      out_data_q;
	logic       out_valid_q;
	logic       advance;
	logic       process;

	// The result register can take a new beat when empty or being drained.
	assign advance   = !out_valid_q || !out_stall;
	assign process   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers; channel width saturates at the track limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.via_limit     <= VIA_LIMIT_RST;
			cfg_q.channel_width <= CHANNEL_WIDTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VIA_LIMIT: begin
					cfg_q.via_limit <= cfg_data;
				end
				REG_CHANNEL_WIDTH: begin
					cfg_q.channel_width <= (cfg_data > MAX_TRACKS_W8) ? MAX_TRACKS_W8 : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			point_s1 <= in_data;
		end
	end

	ccmm_point u_point (
		.cfg        (cfg_q),
		.state      (state_q),
		.point      (point_s1),
		.state_next (state_next),
		.span_valid (span_valid_c),
		.span       (span_c)
	);

	// Run state moves on as each point leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (process) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && span_valid_c;
		end
	end

	always_ff @(posedge clk) begin
		if (process && span_valid_c) begin
			out_data_q <= span_c;
		end
	end

endmodule

FILE: sim/ccmm_span_checker.sv
// Span checker for the channel column metal maximizer.
// Watches the point, span and register channels, predicts every span and compares it.
// Depends on ccmm_pkg.
module ccmm_span_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  ccmm_pkg::point_t in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  ccmm_pkg::span_t  out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output int               mismatches,
	output int               pending
);
	import ccmm_pkg::*;

	// Shadow copy of the registers and of the open-run state.
	logic [7:0] via_limit;
	logic [7:0] channel_width;
	run_state_t run;

	// Spans predicted but not yet seen on the span channel, oldest first.
	span_t spans_due[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Updates the run state for one point and queues the span that it closes, if any.
	task automatic predict_span(input point_t p);
		logic [8:0] top_row;
		logic through, crossing, prev_contact, need_hi, has_hi, convert;
		logic [7:0] top;
		int vias;
		span_t s;
		top_row = {1'b0, channel_width} + 9'd1;
		// Points above the top boundary row leave everything untouched.
		if ({1'b0, p.row} > top_row) return;
		prev_contact = run.prior_row_contact;
		run.prior_row_contact = p.has_contact;
		through = p.goes_right & p.left_goes_right;
		crossing = through & ~p.has_contact;

		// Row zero starts a new column and drops any open run silently.
		if (p.row == 8'd0) begin
			run.run_open = p.goes_up & p.metal_ok_beyond & ~p.metal_blocked;
			if (run.run_open) begin
				run.run_start = 8'd0;
				run.low_contact_needed = 1'b0;
				run.low_contact_present = 1'b0;
			end
			return;
		end

		if (!run.run_open) begin
			if (!p.metal_blocked && p.goes_up && !crossing) begin
				run.run_open = 1'b1;
				run.run_start = p.row;
				run.low_contact_needed = ~through;
				run.low_contact_present = p.has_contact;
			end
			return;
		end

		// Work out where the open run ends and what its upper end needs.
		if (p.metal_blocked || crossing) begin
			top = p.row - 8'd1;
			has_hi = prev_contact;
			need_hi = 1'b1;
		end else if ({1'b0, p.row} == top_row) begin
			if (p.metal_ok_beyond) begin
				top = p.row;
				need_hi = 1'b0;
				has_hi = 1'b0;
			end else begin
				top = p.row - 8'd1;
				has_hi = prev_contact;
				need_hi = 1'b1;
			end
		end else if (!p.goes_up) begin
			top = p.row;
			need_hi = 1'b0;
			has_hi = 1'b1;
		end else begin
			return;
		end

		// A span becomes metal if it adds at most one via or is long enough anyway.
		vias = int'(run.low_contact_needed) + int'(need_hi) - int'(has_hi)
			- int'(run.low_contact_present);
		convert = (run.run_start < top) &&
			(vias <= 1 || (top - run.run_start) >= via_limit);
		s.convert = convert;
		s.span_bottom = run.run_start;
		s.span_top = top;
		s.contact_at_bottom = convert & run.low_contact_needed;
		s.contact_at_top = convert & need_hi;
		spans_due.push_back(s);
		run.run_open = 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Register writes, span beats and point beats, all taken at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		span_t want;
		if (!arst_n) begin
			via_limit = VIA_LIMIT_RST;
			channel_width = CHANNEL_WIDTH_RST;
			run = '0;
			spans_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_VIA_LIMIT: begin
						via_limit = cfg_data;
					end
					REG_CHANNEL_WIDTH: begin
						channel_width = (cfg_data > MAX_TRACKS_W8) ? MAX_TRACKS_W8 : cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (spans_due.size() == 0) begin
					$error("span beat with none expected: span_bottom %0d, span_top %0d",
						out_data.span_bottom, out_data.span_top);
					mismatches++;
				end else begin
					want = spans_due.pop_front();
					check_field("convert", want.convert, out_data.convert);
					check_field("span_bottom", want.span_bottom, out_data.span_bottom);
					check_field("span_top", want.span_top, out_data.span_top);
					check_field("contact_at_bottom", want.contact_at_bottom,
						out_data.contact_at_bottom);
					check_field("contact_at_top", want.contact_at_top, out_data.contact_at_top);
				end
			end
			if (in_valid && !in_stall) begin
				predict_span(in_data);
			end
			pending = spans_due.size();
		end
	end

endmodule

FILE: sim/channel_column_metal_maximizer_core_test.sv
// Testbench top for the channel column metal maximizer.
// Drives grid points, register writes and receiver stalls; the span checker does the comparing.
// Depends on ccmm_pkg, channel_column_metal_maximizer_core and ccmm_span_checker.
module channel_column_metal_maximizer_core_test;
	import ccmm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	point_t     in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	span_t      out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	int         mismatches;
	int         pending;

	// Idling controls of the sender and the receiver, current width, cycle count.
	int gap_pct = 0;
	int stall_pct = 0;
	bit long_hold = 1'b0;
	int cur_width = MAX_TRACKS;
	int cycle_count = 0;

	channel_column_metal_maximizer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ccmm_span_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("channel_column_metal_maximizer_core test failed");
			$finish;
		end
	end

	// Receiver: short random stall bursts, or one long hold when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic point_t pt(input logic [7:0] row, input logic up, input logic right,
		input logic contact, input logic blocked, input logic left_right, input logic ok);
		return '{row, up, right, contact, blocked, left_right, ok};
	endfunction

	// Offers one point, maybe after a short gap, and returns at the edge that takes it.
	task automatic send_point(input point_t p);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Stops sending and lets every expected span come out, plus the pipeline depth.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers; only called while the block is idle.
	task automatic set_config(input logic [7:0] via, input logic [7:0] width);
		cfg_valid <= 1'b1;
		cfg_index <= REG_VIA_LIMIT;
		cfg_data <= via;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_index <= REG_CHANNEL_WIDTH;
		cfg_data <= width;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cur_width = (int'(width) > MAX_TRACKS) ? MAX_TRACKS : int'(width);
	endtask

	// Mostly well-formed columns with random flags, with stray points mixed in.
	task automatic run_columns(input int goal, input int max_step);
		int made;
		int r;
		int top_row;
		int k;
		logic [31:0] noise;
		point_t p;
		made = 0;
		top_row = cur_width + 1;
		while (made < goal) begin
			noise = $urandom;
			p = noise[$bits(point_t)-1:0];
			if ($urandom_range(0, 9) == 0) begin
				// Stray point anywhere in the row range.
				send_point(p);
				if (int'(p.row) <= top_row) made++;
			end else begin
				p.row = 8'd0;
				p.goes_up = ($urandom_range(0, 7) != 0);
				p.metal_ok_beyond = ($urandom_range(0, 7) != 0);
				p.metal_blocked = ($urandom_range(0, 9) == 0);
				send_point(p);
				made++;
				r = 0;
				while (r < top_row) begin
					k = $urandom_range(0, 19);
					if (k != 0) begin
						k = $urandom_range(1, max_step);
						r = (r + k > top_row) ? top_row : r + k;
					end
					noise = $urandom;
					p = noise[$bits(point_t)-1:0];
					p.row = 8'(r);
					p.goes_up = ($urandom_range(0, 5) != 0);
					p.metal_blocked = ($urandom_range(0, 11) == 0);
					send_point(p);
					made++;
				end
				// Now and then a point beyond the top boundary row.
				if (top_row < 255 && $urandom_range(0, 4) == 0) begin
					p.row = 8'($urandom_range(top_row + 1, 255));
					send_point(p);
				end
			end
		end
	endtask

	// Alternating open and close points while the receiver holds off, so the block fills.
	task automatic fill_under_hold();
		int i;
		int r;
		point_t p;
		logic [31:0] noise;
		long_hold = 1'b1;
		gap_pct = 0;
		for (i = 0; i < 24; i++) begin
			r = i % 4;
			noise = $urandom;
			p = noise[$bits(point_t)-1:0];
			p.row = 8'(r);
			p.goes_up = (r % 2 == 0);
			p.goes_right = 1'b0;
			p.metal_blocked = 1'b0;
			p.metal_ok_beyond = 1'b1;
			send_point(p);
		end
	endtask

	initial begin
		point_t directed[$];
		logic [7:0] via_tab[6];
		logic [7:0] width_tab[6];
		int step_tab[6];
		int i;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points on a column of width 4 (rows 0 to 5): every way of opening and closing a run.
		gap_pct = 20;
		stall_pct = 20;
		set_config(8'd2, 8'd4);
		directed.push_back(pt(8'd0, 1, 0, 0, 0, 0, 1));
		directed.push_back(pt(8'd1, 1, 0, 1, 0, 0, 0));
		directed.push_back(pt(8'd2, 0, 0, 0, 0, 0, 0));   // wire end
		directed.push_back(pt(8'd0, 1, 0, 0, 0, 0, 0));   // channel below refuses metal
		directed.push_back(pt(8'd1, 1, 1, 1, 0, 1, 0));   // connected crossing opens a run
		directed.push_back(pt(8'd2, 1, 0, 0, 1, 0, 0));   // metal block, empty span
		directed.push_back(pt(8'd0, 1, 0, 0, 1, 0, 1));
		directed.push_back(pt(8'd1, 1, 0, 0, 0, 0, 0));
		directed.push_back(pt(8'd2, 1, 0, 0, 0, 0, 0));
		directed.push_back(pt(8'd3, 1, 1, 0, 0, 1, 0));   // unconnected crossing, two vias
		directed.push_back(pt(8'd0, 1, 0, 0, 0, 0, 1));
		directed.push_back(pt(8'd1, 1, 0, 0, 0, 0, 0));
		directed.push_back(pt(8'd2, 1, 0, 0, 0, 0, 0));
		directed.push_back(pt(8'd2, 1, 0, 0, 0, 0, 0));   // repeated row
		directed.push_back(pt(8'd4, 1, 0, 0, 0, 0, 0));   // skipped row
		directed.push_back(pt(8'd5, 1, 0, 0, 0, 0, 1));   // top row into open channel
		directed.push_back(pt(8'd0, 1, 0, 0, 0, 0, 1));
		directed.push_back(pt(8'd3, 1, 0, 1, 0, 0, 0));
		directed.push_back(pt(8'd5, 0, 0, 0, 0, 0, 0));   // top row into closed channel
		directed.push_back(pt(8'd0, 0, 0, 0, 0, 0, 0));
		directed.push_back(pt(8'd5, 1, 0, 0, 0, 0, 1));   // run opens on the top row
		directed.push_back(pt(8'd6, 1, 1, 1, 1, 1, 1));   // above the top row
		directed.push_back(pt(8'd255, 1, 1, 1, 1, 1, 1));
		directed.push_back(pt(8'd0, 1, 1, 1, 0, 1, 1));   // drops the run left open
		directed.push_back(pt(8'd1, 0, 1, 1, 1, 1, 0));
		foreach (directed[j]) send_point(directed[j]);
		wait_idle();

		// Random phases over a spread of register settings, extremes included.
		via_tab = '{8'd0, 8'd255, 8'd1, 8'd3, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		width_tab = '{8'd1, 8'd3, 8'd6, 8'd12, 8'($urandom_range(1, 20)), 8'd255};
		step_tab = '{1, 1, 1, 2, 3, 16};
		for (i = 0; i < 6; i++) begin
			gap_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 35);
			stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 35);
			set_config(via_tab[i], width_tab[i]);
			run_columns(i == 5 ? 60 : 80, step_tab[i]);
			wait_idle();
		end

		// Long receiver hold with the sender pushing, then a full drain.
		set_config(8'd2, 8'd4);
		stall_pct = 0;
		fill_under_hold();
		wait_idle();

		// Closing stretch without idling on either side.
		gap_pct = 0;
		stall_pct = 0;
		set_config(8'($urandom_range(0, 255)), 8'd8);
		run_columns(80, 2);
		wait_idle();

		if (mismatches == 0 && pending == 0) begin
			$display("channel_column_metal_maximizer_core test passed");
		end else begin
			$display("channel_column_metal_maximizer_core test failed");
		end
		$finish;
	end

endmodule
